>>> rtl/sudp_pkg.sv
// Shared types and constants for the proxy UDP request header parser.
// No dependencies; imported by every module of the block.
package sudp_pkg;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned M_TUSER_W = 2;

    // Header layout
    localparam logic [1:0] POS_FRAG = 2'd2;
    localparam logic [1:0] POS_ATYP = 2'd3;
    localparam logic [7:0] ATYP_IPV4 = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN = 8'd3;
    localparam logic [7:0] ATYP_IPV6 = 8'd4;
    localparam logic [7:0] IPV4_LEN = 8'd4;
    localparam logic [7:0] IPV6_LEN = 8'd16;
    // Smallest datagram length in bytes that can end without an error result
    localparam logic [3:0] MIN_PACKET = 4'd8;
    localparam logic [3:0] TOTAL_MAX = 4'd15;

    localparam logic ERR_MALFORMED = 1'b0;
    localparam logic ERR_ATYP = 1'b1;

    typedef enum logic [2:0] {
        PH_HDR = 3'd0,
        PH_DLEN = 3'd1,
        PH_ADDR = 3'd2,
        PH_PHI = 3'd3,
        PH_PLO = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DRAIN = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ADDR = 2'd0,
        KIND_HDR = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERR = 2'd3
    } kind_t;

    typedef struct packed {
        logic have;
        kind_t kind;
        logic [7:0] byte_out;
        logic [7:0] addr_type;
        logic [15:0] dest_port;
        logic error_code;
        logic end_of_packet;
    } result_t;

    typedef struct packed {
        phase_t phase;
        logic [3:0] total_seen;
        logic error_pending;
    } parse_status_t;

endpackage

>>> rtl/sudp_in_stage.sv
// Input register stage of the proxy UDP header parser.
// Depends on sudp_pkg for widths.
module sudp_in_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sudp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           advance,
    output logic                           item_valid,
    output logic [7:0]                     item_byte,
    output logic                           item_last
);
    import sudp_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Take a new item whenever the register is empty or the held one leaves this cycle.
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata[7:0];
            last_reg <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte = byte_reg;
    assign item_last = last_reg;

endmodule

>>> rtl/sudp_parse.sv
// Header parse state and result decode, one datagram byte per step.
// Depends on sudp_pkg for phase, kind and result types.
module sudp_parse (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic [7:0]              item_byte,
    input  logic                    item_last,
    output sudp_pkg::result_t       result,
    output sudp_pkg::parse_status_t status
);
    import sudp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [1:0] pos_reg, pos_next;
    logic [3:0] total_reg, total_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] phi_reg, phi_next;
    logic       errp_reg, errp_next;
    logic       errk_reg, errk_next;
    logic [7:0] left_dec;
    logic       bad;

    assign left_dec = left_reg - 8'd1;

    // Next state, before the end-of-datagram clear
    always_comb begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        type_next = type_reg;
        left_next = left_reg;
        phi_next = phi_reg;
        errp_next = errp_reg;
        errk_next = errk_reg;
        total_next = (total_reg < TOTAL_MAX) ? total_reg + 4'd1 : total_reg;
        unique case (phase_reg)
            PH_HDR: begin
                if (pos_reg == POS_FRAG && item_byte != 8'd0) begin
                    if (!errp_reg) begin
                        errp_next = 1'b1;
                        errk_next = ERR_MALFORMED;
                    end
                    phase_next = PH_DRAIN;
                end else if (pos_reg == POS_ATYP) begin
                    type_next = item_byte;
                    unique case (item_byte)
                        ATYP_IPV4: begin
                            left_next = IPV4_LEN;
                            phase_next = PH_ADDR;
                        end
                        ATYP_IPV6: begin
                            left_next = IPV6_LEN;
                            phase_next = PH_ADDR;
                        end
                        ATYP_DOMAIN: begin
                            phase_next = PH_DLEN;
                        end
                        default: begin
                            if (!errp_reg) begin
                                errp_next = 1'b1;
                                errk_next = ERR_ATYP;
                            end
                            phase_next = PH_DRAIN;
                        end
                    endcase
                end
                pos_next = pos_reg + 2'd1;
            end
            PH_DLEN: begin
                left_next = item_byte;
                phase_next = (item_byte == 8'd0) ? PH_PHI : PH_ADDR;
            end
            PH_ADDR: begin
                left_next = left_dec;
                if (left_dec == 8'd0) begin
                    phase_next = PH_PHI;
                end
            end
            PH_PHI: begin
                phi_next = item_byte;
                phase_next = PH_PLO;
            end
            PH_PLO: begin
                phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
            end
            PH_DRAIN: begin
            end
            default: begin
                phase_next = PH_DRAIN;
            end
        endcase
    end

    // Result for this byte; the final byte always yields one
    always_comb begin
        result = '0;
        result.addr_type = type_next;
        result.end_of_packet = item_last;
        unique case (phase_reg)
            PH_ADDR: begin
                result.have = 1'b1;
                result.kind = KIND_ADDR;
                result.byte_out = item_byte;
            end
            PH_PLO: begin
                result.have = 1'b1;
                result.kind = KIND_HDR;
                result.dest_port = {phi_reg, item_byte};
            end
            PH_PAYLOAD: begin
                result.have = 1'b1;
                result.kind = KIND_PAYLOAD;
                result.byte_out = item_byte;
            end
            default: begin
            end
        endcase
        bad = (total_next < MIN_PACKET) || errp_next || (phase_next != PH_PAYLOAD);
        if (item_last) begin
            result.have = 1'b1;
            if (bad) begin
                result.kind = KIND_ERR;
                result.byte_out = 8'd0;
                result.dest_port = 16'd0;
                result.error_code = (total_next < MIN_PACKET) ? ERR_MALFORMED :
                                    errp_next ? errk_next : ERR_MALFORMED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR;
            pos_reg <= 2'd0;
            total_reg <= 4'd0;
            type_reg <= 8'd0;
            left_reg <= 8'd0;
            phi_reg <= 8'd0;
            errp_reg <= 1'b0;
            errk_reg <= 1'b0;
        end else if (step) begin
            if (item_last) begin
                phase_reg <= PH_HDR;
                pos_reg <= 2'd0;
                total_reg <= 4'd0;
                type_reg <= 8'd0;
                left_reg <= 8'd0;
                phi_reg <= 8'd0;
                errp_reg <= 1'b0;
                errk_reg <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                pos_reg <= pos_next;
                total_reg <= total_next;
                type_reg <= type_next;
                left_reg <= left_next;
                phi_reg <= phi_next;
                errp_reg <= errp_next;
                errk_reg <= errk_next;
            end
        end
    end

    assign status.phase = phase_reg;
    assign status.total_seen = total_reg;
    assign status.error_pending = errp_reg;

endmodule

>>> rtl/sudp_out_stage.sv
// Result register of the proxy UDP header parser, packs the output stream.
// Depends on sudp_pkg for the result type and stream widths.
module sudp_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  sudp_pkg::result_t              result,
    output logic                           can_load,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sudp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [sudp_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast
);
    import sudp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = {7'd0, res_reg.error_code, res_reg.dest_port,
                      res_reg.addr_type, res_reg.byte_out};
    assign m_tuser = res_reg.kind;
    assign m_tlast = res_reg.end_of_packet;

endmodule

>>> rtl/socks5_udp_header_parser_core.sv
// Top level of the proxy UDP request header parser.
// Depends on sudp_pkg, sudp_in_stage, sudp_parse and sudp_out_stage.
//
//  channel | dir | signals                      | carries
//  --------+-----+------------------------------+------------------------------------
//  s_      | in  | tvalid tready tdata tlast    | one datagram byte, tlast on the last
//  m_      | out | tvalid tready tdata tuser    | address byte, header done, payload
//          |     | tlast                        | byte or error; tlast ends datagram
//
// One item per cycle sustained while m_ does not stall; each item passes the input
// register, one pass of parse logic and the result register, so its result is
// registered before it shows on m_. Bytes that yield no result (reserved, fragment,
// type, name length, port high, bytes after an error) still pass the input register
// and wait there until the result register can load. Reset clears both valid flags
// and the parse state. A stall on m_ holds the result register; the input register
// keeps taking items until it is full.
module socks5_udp_header_parser_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sudp_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic                           s_tlast,  // final_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] byte_out, [15:8] addr_type, [31:16] dest_port, [32] error_code, rest 0
    output logic [sudp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [sudp_pkg::M_TUSER_W-1:0] m_tuser,  // [1:0] kind
    output logic                           m_tlast   // end_of_packet
);
    import sudp_pkg::*;

    logic          item_valid;
    logic [7:0]    item_byte;
    logic          item_last;
    logic          can_load;
    logic          advance;
    result_t       result;
    parse_status_t status;

    // Advance the held byte whenever the result register can take its result.
    assign advance = item_valid && can_load;

    sudp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_last  (item_last)
    );

    sudp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item_byte (item_byte),
        .item_last (item_last),
        .result    (result),
        .status    (status)
    );

    // Drop bytes without a result; load the rest.
    sudp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && result.have),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The final byte of a datagram always returns the parser to its start.
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item_last |=> status.phase == PH_HDR && status.total_seen == 4'd0
            && !status.error_pending)
        else $error("parse state not cleared after final byte");

    // An error result only ever closes a datagram.
    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERR |-> m_tlast)
        else $error("error result without end of packet");

    // A datagram that ends cleanly ends on a payload byte or on the port's low byte.
    a_clean_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tuser != KIND_ERR
            |-> m_tuser == KIND_PAYLOAD || m_tuser == KIND_HDR)
        else $error("clean end of packet on an address result");

    // Only the header-done result carries a port.
    a_port_only_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_HDR |-> m_tdata[31:16] == 16'd0)
        else $error("port set on a result that is not header done");

endmodule

>>> verif/socks5_udp_header_parser_core_test.sv
// Self-checking testbench for socks5_udp_header_parser_core: drives datagram bytes
// on s_, predicts every result in its own parser copy and compares each m_ item.
// Depends on sudp_pkg for the phase and kind enums and the header constants.
module socks5_udp_header_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sudp_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1600;
    localparam int unsigned LONG_HOLD = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_out;
        logic [7:0]  addr_type;
        logic [15:0] dest_port;
        logic        error_code;
        logic        eop;
    } parse_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    // Datagram bytes waiting to be offered, and results predicted but not yet seen.
    stream_item_t  datagram_bytes[$];
    parse_result_t expected_results[$];
    logic [7:0]    frame[$];

    // Parser copy: mirrors the block's header walk byte by byte.
    phase_t     ph;
    logic [1:0] hdr_pos;
    logic [3:0] seen_cnt;
    logic [7:0] atyp_held;
    logic [7:0] addr_remaining;
    logic [7:0] port_hi;
    logic       err_held;
    logic       err_code_held;

    int unsigned items_total = 0;
    int unsigned items_sent = 0;
    int unsigned items_accepted = 0;
    int unsigned datagrams = 0;
    int unsigned results_seen = 0;
    int unsigned error_results = 0;
    int unsigned header_results = 0;
    int unsigned mismatches = 0;

    int unsigned send_gap = 0;
    logic        sender_steady = 1'b0;
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    logic        recv_steady = 1'b0;

    socks5_udp_header_parser_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function void clear_parse_state();
        ph = PH_HDR;
        hdr_pos = 2'd0;
        seen_cnt = 4'd0;
        atyp_held = 8'h00;
        addr_remaining = 8'h00;
        port_hi = 8'h00;
        err_held = 1'b0;
        err_code_held = ERR_MALFORMED;
    endfunction

    // Keep the first error of a datagram; drop everything after it.
    function void flag_error(input logic code);
        if (!err_held) begin
            err_held = 1'b1;
            err_code_held = code;
        end
        ph = PH_DRAIN;
    endfunction

    // Advance the parser copy by one accepted byte and queue the result it causes.
    function automatic void parse_byte(input logic [7:0] b, input logic fin);
        parse_result_t r;
        logic          have;
        logic          bad;
        have = 1'b0;
        bad = 1'b1;
        r.kind = KIND_ADDR;
        r.byte_out = 8'h00;
        r.dest_port = 16'h0000;
        r.error_code = ERR_MALFORMED;
        r.eop = fin;
        if (seen_cnt != TOTAL_MAX)
            seen_cnt = seen_cnt + 4'd1;
        case (ph)
            PH_HDR: begin
                if (hdr_pos == POS_FRAG && b != 8'h00) begin
                    flag_error(ERR_MALFORMED);
                end else if (hdr_pos == POS_ATYP) begin
                    atyp_held = b;
                    if (b == ATYP_IPV4) begin
                        addr_remaining = IPV4_LEN;
                        ph = PH_ADDR;
                    end else if (b == ATYP_IPV6) begin
                        addr_remaining = IPV6_LEN;
                        ph = PH_ADDR;
                    end else if (b == ATYP_DOMAIN) begin
                        ph = PH_DLEN;
                    end else begin
                        flag_error(ERR_ATYP);
                    end
                end
                hdr_pos = hdr_pos + 2'd1;
            end
            PH_DLEN: begin
                // An empty name goes straight to the port.
                addr_remaining = b;
                ph = (b == 8'h00) ? PH_PHI : PH_ADDR;
            end
            PH_ADDR: begin
                have = 1'b1;
                r.kind = KIND_ADDR;
                r.byte_out = b;
                addr_remaining = addr_remaining - 8'd1;
                if (addr_remaining == 8'h00)
                    ph = PH_PHI;
            end
            PH_PHI: begin
                port_hi = b;
                ph = PH_PLO;
            end
            PH_PLO: begin
                have = 1'b1;
                r.kind = KIND_HDR;
                r.dest_port = {port_hi, b};
                ph = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                have = 1'b1;
                r.kind = KIND_PAYLOAD;
                r.byte_out = b;
            end
            default: begin
            end
        endcase
        // The final byte always yields one result; a short packet wins over
        // a held error, which wins over a header cut off before the port.
        if (fin) begin
            if (seen_cnt < MIN_PACKET)
                r.error_code = ERR_MALFORMED;
            else if (err_held)
                r.error_code = err_code_held;
            else if (ph != PH_PAYLOAD)
                r.error_code = ERR_MALFORMED;
            else
                bad = 1'b0;
            if (bad) begin
                r.kind = KIND_ERR;
                r.byte_out = 8'h00;
                r.dest_port = 16'h0000;
            end else begin
                r.error_code = ERR_MALFORMED;
            end
            have = 1'b1;
        end
        r.addr_type = atyp_held;
        if (have)
            expected_results.push_back(r);
        if (fin)
            clear_parse_state();
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue the first cut bytes of the frame under construction as one datagram.
    function void send_frame(input int unsigned cut);
        stream_item_t it;
        for (int unsigned i = 0; i < cut; i++) begin
            it.data = frame[i];
            it.last = (i == cut - 1);
            datagram_bytes.push_back(it);
        end
        items_total += cut;
        datagrams++;
        frame.delete();
    endfunction

    // Directed datagrams are written most significant byte first.
    function void queue_bytes(input logic [127:0] bytes, input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            frame.push_back(bytes[8*(n-1-i) +: 8]);
        send_frame(n);
    endfunction

    // Well-formed header with random address type, address, port and payload.
    function automatic void build_valid_frame();
        int unsigned sel;
        int unsigned alen;
        logic [7:0]  atyp;
        sel = $urandom_range(0, 2);
        atyp = (sel == 0) ? ATYP_IPV4 : (sel == 1) ? ATYP_IPV6 : ATYP_DOMAIN;
        frame.push_back(rand_byte());
        frame.push_back(rand_byte());
        frame.push_back(8'h00);
        frame.push_back(atyp);
        if (atyp == ATYP_IPV4) begin
            alen = IPV4_LEN;
        end else if (atyp == ATYP_IPV6) begin
            alen = IPV6_LEN;
        end else begin
            // Mostly short names, now and then one near the 255-byte limit.
            alen = ($urandom_range(0, 40) == 0) ? $urandom_range(200, 255)
                                                : $urandom_range(0, 12);
            frame.push_back(8'(alen));
        end
        repeat (alen) frame.push_back(rand_byte());
        frame.push_back(rand_byte());
        frame.push_back(rand_byte());
        repeat ($urandom_range(0, 10)) frame.push_back(rand_byte());
    endfunction

    function void check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Driver: hold an item until taken, then wait its drawn gap and offer the next.
    always @(posedge aclk) begin
        stream_item_t cur;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            send_gap = 0;
            clear_parse_state();
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                items_accepted++;
                parse_byte(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (datagram_bytes.size() != 0) begin
                    cur = datagram_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= cur.data;
                    s_tlast <= cur.last;
                    items_sent++;
                    // Switch between back-to-back bursts and gappy stretches.
                    if (items_sent % 64 == 0)
                        sender_steady = ($urandom_range(0, 3) == 0);
                    send_gap = sender_steady ? 0 : $urandom_range(0, 7);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result with the oldest prediction, then pace ready.
    always @(posedge aclk) begin
        parse_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: tuser 0x%0h tdata 0x%0h",
                           m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.kind == KIND_ERR)
                        error_results++;
                    if (want.kind == KIND_HDR)
                        header_results++;
                    check_field("kind", 16'(want.kind), 16'(m_tuser));
                    check_field("byte_out", 16'(want.byte_out), 16'(m_tdata[7:0]));
                    check_field("addr_type", 16'(want.addr_type), 16'(m_tdata[15:8]));
                    check_field("dest_port", want.dest_port, m_tdata[31:16]);
                    check_field("error_code", 16'(want.error_code), 16'(m_tdata[32]));
                    check_field("tdata_pad", 16'h0000, 16'(m_tdata[M_TDATA_W-1:33]));
                    check_field("end_of_packet", 16'(want.eop), 16'(m_tlast));
                end
                if (results_seen % 40 == 0)
                    recv_steady = ($urandom_range(0, 3) == 0);
                recv_wait = recv_steady ? 0 : $urandom_range(0, 7);
                // Hold off long enough for the block to fill and stall s_.
                if (results_seen == 200 || results_seen == 700)
                    hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_wait != 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned pick;
        int unsigned cut;
        logic [7:0]  v;

        // IPv4, all-ones and all-zero address bytes, largest port, ends on the port.
        queue_bytes(128'h00_00_00_01_FF_00_80_01_FF_FF, 10);
        // Empty name completes the header in 7 bytes: still too short.
        queue_bytes(128'hFF_FF_00_03_00_12_34, 7);
        // Nonzero fragment: rest of the datagram is dropped.
        queue_bytes(128'h00_00_80_01_00_00_00_00, 8);
        // Unknown address type with exactly the minimum length.
        queue_bytes(128'h00_00_00_FF_01_02_03_04, 8);

        while (items_total < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            build_valid_frame();
            cut = frame.size();
            if (pick < 65) begin
                // well-formed, keep as is
            end else if (pick < 75) begin
                frame[2] = 8'($urandom_range(1, 255));
            end else if (pick < 85) begin
                v = rand_byte();
                while (v == ATYP_IPV4 || v == ATYP_IPV6 || v == ATYP_DOMAIN)
                    v = rand_byte();
                frame[3] = v;
            end else if (pick < 95) begin
                cut = $urandom_range(1, frame.size() - 1);
            end else begin
                frame.delete();
                cut = $urandom_range(1, 20);
                repeat (cut) frame.push_back(rand_byte());
            end
            send_frame(cut);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted != items_total) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        // Leave room for any stray result.
        repeat (8) @(posedge aclk);

        $display("Sent %0d bytes in %0d datagrams; checked %0d results", items_accepted,
                 datagrams, results_seen);
        $display("  of which %0d header-done and %0d error results", header_results,
                 error_results);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout: %0d of %0d bytes accepted, %0d results pending", items_accepted,
                 items_total, expected_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
